@@ src/msbfp_pkg.sv @@
// Shared types and helpers for the MSB-first field packer.
`default_nettype none

package msbfp_pkg;

    // Field codes carried on the request op port
    typedef enum logic [3:0] {
        OP_NIBBLE   = 4'd0,
        OP_BYTE     = 4'd1,
        OP_U16      = 4'd2,
        OP_U32      = 4'd3,
        OP_U64      = 4'd4,
        OP_RAW8     = 4'd5,
        OP_FLAG     = 4'd6,
        OP_RSV_BIT  = 4'd7,
        OP_RSV_BYTE = 4'd8,
        OP_ATTR     = 4'd9,
        OP_FLUSH    = 4'd10
    } op_t;

    localparam int unsigned OP_W    = 4;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned CNT_W   = 3;

    localparam logic [BYTE_W-1:0] NIBBLE_HI_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] FMT_BIT_MASK   = 8'h80;

    // One queued job: bytes left-justified, first stream byte in the top lane
    typedef struct packed {
        logic [VALUE_W-1:0] data;
        logic [CNT_W-1:0]   cnt;   // number of results minus one
        logic               err;   // single error result
    } desc_t;

    // Reverse byte order of a 64-bit word
    function automatic logic [VALUE_W-1:0] byte_swap(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        r = '0;
        for (int i = 0; i < VALUE_W / BYTE_W; i++) begin
            r[VALUE_W-1-BYTE_W*i -: BYTE_W] = v[BYTE_W*i +: BYTE_W];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/msbfp_front.sv @@
// Front end: accepts field requests, tracks the open byte and queues byte jobs.
`default_nettype none

module msbfp_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [msbfp_pkg::OP_W-1:0]     s_op,
    input  wire logic [msbfp_pkg::VALUE_W-1:0]  s_value,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           q_full,
    output logic                                push_valid,
    output msbfp_pkg::desc_t                    push_desc
);
    import msbfp_pkg::*;

    logic [BYTE_W-1:0] partial_reg, partial_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              accept;
    logic              push;
    desc_t             desc;
    logic              bit_val;
    logic [BYTE_W-1:0] bit_byte;

    assign s_ready = ~q_full;
    assign accept  = s_valid & s_ready;

    // Classify the request and work out the new bit state
    always_comb begin
        partial_next = partial_reg;
        pos_next     = pos_reg;
        push         = 1'b0;
        desc.data    = '0;
        desc.cnt     = '0;
        desc.err     = 1'b0;
        bit_val      = (op_t'(s_op) == OP_FLAG) ? (s_value != '0) : 1'b0;
        bit_byte     = (pos_reg == '0) ? '0 : partial_reg;
        bit_byte[3'd7 - pos_reg] = bit_val;

        unique case (op_t'(s_op))
            OP_NIBBLE: begin
                if (pos_reg == 3'd0) begin
                    partial_next = {s_value[3:0], 4'h0};
                    pos_next     = 3'd4;
                end else if (pos_reg == 3'd4) begin
                    push = 1'b1;
                    desc.data[63:56] = (partial_reg & NIBBLE_HI_MASK) | {4'h0, s_value[3:0]};
                    partial_next = '0;
                    pos_next     = '0;
                end else begin
                    push     = 1'b1;
                    desc.err = 1'b1;
                end
            end
            OP_BYTE, OP_U16, OP_U32, OP_U64, OP_RAW8, OP_RSV_BYTE: begin
                push = 1'b1;
                if (pos_reg != 3'd0) begin
                    desc.err = 1'b1;
                end else begin
                    case (op_t'(s_op))
                        OP_BYTE: begin
                            desc.data = {s_value[7:0], 56'd0};
                            desc.cnt  = 3'd0;
                        end
                        OP_U16: begin
                            desc.data = {s_value[15:0], 48'd0};
                            desc.cnt  = 3'd1;
                        end
                        OP_U32: begin
                            desc.data = {s_value[31:0], 32'd0};
                            desc.cnt  = 3'd3;
                        end
                        OP_U64: begin
                            desc.data = s_value;
                            desc.cnt  = 3'd7;
                        end
                        OP_RAW8: begin
                            desc.data = byte_swap(s_value);
                            desc.cnt  = 3'd7;
                        end
                        default: begin
                            desc.data = '0;
                            desc.cnt  = 3'd0;
                        end
                    endcase
                    partial_next = '0;
                end
            end
            OP_FLAG, OP_RSV_BIT: begin
                if (pos_reg == 3'd7) begin
                    push = 1'b1;
                    desc.data[63:56] = bit_byte;
                    partial_next = '0;
                    pos_next     = '0;
                end else begin
                    partial_next = bit_byte;
                    pos_next     = pos_reg + 3'd1;
                end
            end
            OP_ATTR: begin
                push = 1'b1;
                if (pos_reg == 3'd1) begin
                    desc.data[63:48] = {(partial_reg & FMT_BIT_MASK) | {1'b0, s_value[14:8]},
                                        s_value[7:0]};
                    desc.cnt         = 3'd1;
                    partial_next     = '0;
                    pos_next         = '0;
                end else begin
                    desc.err = 1'b1;
                end
            end
            OP_FLUSH: begin
                if (pos_reg != 3'd0) begin
                    push = 1'b1;
                    desc.data[63:56] = partial_reg;
                    partial_next = '0;
                    pos_next     = '0;
                end
            end
            default: begin
                push     = 1'b1;
                desc.err = 1'b1;
            end
        endcase

        // Misaligned fields leave the state untouched
        if (desc.err) begin
            partial_next = partial_reg;
            pos_next     = pos_reg;
        end
    end

    assign push_valid = accept & push;
    assign push_desc  = desc;

    // Hold the open byte and bit position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            pos_reg     <= '0;
        end else if (accept) begin
            partial_reg <= partial_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

`default_nettype wire

@@ src/msbfp_queue.sv @@
// Two-entry job queue between front end and byte serialiser.
`default_nettype none

module msbfp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    input  wire msbfp_pkg::desc_t push_desc,
    output logic                  full,
    output logic                  pop_valid,
    output msbfp_pkg::desc_t      pop_desc,
    input  wire logic             pop
);
    import msbfp_pkg::*;

    desc_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_desc  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop & pop_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push_valid;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push_valid} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming jobs
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

@@ src/msbfp_back.sv @@
// Back end: shifts queued jobs out one byte per request on the result channel.
`default_nettype none

module msbfp_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire msbfp_pkg::desc_t              q_desc,
    output logic                               q_pop,
    output logic [msbfp_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                               m_byte_valid,
    output logic                               m_error,
    output logic                               m_last,
    output logic                               m_valid,
    input  wire logic                          m_ready
);
    import msbfp_pkg::*;

    logic               busy_reg, busy_next;
    logic [VALUE_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               err_reg, err_next;
    logic               take;

    // Load a new job when idle or when the last byte leaves
    assign take  = ~busy_reg | (m_ready & (cnt_reg == '0));
    assign q_pop = take & q_valid;

    always_comb begin
        busy_next = busy_reg;
        data_next = data_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        if (take) begin
            busy_next = q_valid;
            data_next = q_desc.data;
            cnt_next  = q_desc.cnt;
            err_next  = q_desc.err;
        end else if (m_ready) begin
            data_next = {data_reg[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // Drive the result request from the shift register
    assign m_valid      = busy_reg;
    assign m_out_byte   = data_reg[VALUE_W-1 -: BYTE_W];
    assign m_byte_valid = ~err_reg;
    assign m_error      = err_reg;
    assign m_last       = (cnt_reg == '0);

endmodule

`default_nettype wire

@@ src/msb_first_field_packer_core.sv @@
// Top level: MSB-first field packer, front end, job queue and byte serialiser.
// Path: accepted requests pass through the job queue into the serialiser's
// shift register. Throughput: one result byte per cycle while m_ready is high;
// a request yields up to eight bytes, with a two-entry job queue in front.
// Requests are taken every cycle while the job queue has room.
// Reset: synchronous, active low; clears the open byte, bit position and queue.
`default_nettype none

module msb_first_field_packer_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [msbfp_pkg::OP_W-1:0]    s_op,
    input  wire logic [msbfp_pkg::VALUE_W-1:0] s_value,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    output logic [msbfp_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                               m_byte_valid,
    output logic                               m_error,
    output logic                               m_last,
    output logic                               m_valid,
    input  wire logic                          m_ready
);
    import msbfp_pkg::*;

    logic  q_full;
    logic  push_valid;
    desc_t push_desc;
    logic  pop_valid;
    desc_t pop_desc;
    logic  q_pop;

    msbfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_op       (s_op),
        .s_value    (s_value),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_desc  (push_desc)
    );

    msbfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_desc   (pop_desc),
        .pop        (q_pop)
    );

    msbfp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (pop_valid),
        .q_desc       (pop_desc),
        .q_pop        (q_pop),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_error      (m_error),
        .m_last       (m_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the MSB-first field packer core.
module testbench;
    import msbfp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 5000;
    localparam int RAND_PER_PHASE = 140;
    localparam int N_DIR          = 25;
    localparam int MAX_REPORTS    = 10;

    // Op codes outside the defined set
    localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 4'd11;
    localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              bv;
        logic              err;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    typed;
        result_t res;
    } req_tag_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic               typed;
        result_t            res;
    } row_t;

    logic                aclk;
    logic                aresetn;
    logic [OP_W-1:0]     s_op;
    logic [VALUE_W-1:0]  s_value;
    logic                s_valid;
    logic                s_ready;
    logic [BYTE_W-1:0]   m_out_byte;
    logic                m_byte_valid;
    logic                m_error;
    logic                m_last;
    logic                m_valid;
    logic                m_ready;

    // Packer image: open byte and next bit position
    logic [BYTE_W-1:0]   pk_open;
    logic [POS_W-1:0]    pk_pos;

    result_t             burst[$];
    result_t             exp_stream[$];
    req_tag_t            req_tags[$];
    row_t                dir_rows [0:N_DIR-1];

    int                  snd_idle_pct;
    int                  rcv_idle_pct;
    logic                hold_req;
    logic                hold_taken;
    int                  hold_left;
    int                  fail_count;
    int                  stall_cycles;

    msb_first_field_packer_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_op         (s_op),
        .s_value      (s_value),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_error      (m_error),
        .m_last       (m_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Append one completed stream byte to the current burst
    task automatic emit_byte(input logic [BYTE_W-1:0] b);
        burst.push_back({b, 1'b1, 1'b0, 1'b0});
    endtask

    // Place a single bit at the current position, closing the byte at bit 7
    task automatic put_bit(input logic b1);
        if (pk_pos == 3'd0) pk_open = '0;
        pk_open[3'd7 - pk_pos] = b1;
        if (pk_pos == 3'd7) begin
            emit_byte(pk_open);
            pk_open = '0;
            pk_pos  = 3'd0;
        end else begin
            pk_pos = pk_pos + 3'd1;
        end
    endtask

    // Work out the bytes one field adds to the stream and advance the image
    task automatic pack_field(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
        logic    misaligned;
        result_t r;
        burst.delete();
        misaligned = 1'b0;
        case (op)
            OP_NIBBLE: begin
                if (pk_pos == 3'd0) begin
                    pk_open = {v[3:0], pk_open[3:0]};
                    pk_pos  = 3'd4;
                end else if (pk_pos == 3'd4) begin
                    emit_byte({pk_open[7:4], v[3:0]});
                    pk_open = '0;
                    pk_pos  = 3'd0;
                end else begin
                    misaligned = 1'b1;
                end
            end
            OP_BYTE, OP_U16, OP_U32, OP_U64, OP_RAW8, OP_RSV_BYTE: begin
                if (pk_pos != 3'd0) begin
                    misaligned = 1'b1;
                end else begin
                    case (op)
                        OP_BYTE:     emit_byte(v[7:0]);
                        OP_U16:      for (int i = 1; i >= 0; i--) emit_byte(v[8*i +: 8]);
                        OP_U32:      for (int i = 3; i >= 0; i--) emit_byte(v[8*i +: 8]);
                        OP_U64:      for (int i = 7; i >= 0; i--) emit_byte(v[8*i +: 8]);
                        OP_RAW8:     for (int i = 0; i < 8; i++) emit_byte(v[8*i +: 8]);
                        default:     emit_byte(8'h00);
                    endcase
                    pk_open = '0;
                end
            end
            OP_FLAG:    put_bit(v != '0);
            OP_RSV_BIT: put_bit(1'b0);
            OP_ATTR: begin
                if (pk_pos != 3'd1) begin
                    misaligned = 1'b1;
                end else begin
                    // Format bit stays on top of the attribute type
                    emit_byte({pk_open[7], v[14:8]});
                    emit_byte(v[7:0]);
                    pk_open = '0;
                    pk_pos  = 3'd0;
                end
            end
            OP_FLUSH: begin
                if (pk_pos != 3'd0) begin
                    emit_byte(pk_open);
                    pk_open = '0;
                    pk_pos  = 3'd0;
                end
            end
            default: misaligned = 1'b1;
        endcase
        if (misaligned) begin
            burst.delete();
            burst.push_back({8'h00, 1'b0, 1'b1, 1'b1});
        end else if (burst.size() > 0) begin
            r = burst.pop_back();
            r.last = 1'b1;
            burst.push_back(r);
        end
    endtask

    // Choose a random request, mostly one that fits the current bit position
    task automatic pick_request(output logic [OP_W-1:0] op, output logic [VALUE_W-1:0] v);
        int k;
        if ($urandom_range(0, 99) < 12) begin
            op = OP_W'($urandom_range(0, 15));
        end else begin
            case (pk_pos)
                3'd0: begin
                    k = $urandom_range(0, 11);
                    case (k)
                        0, 1:    op = OP_NIBBLE;
                        2:       op = OP_BYTE;
                        3:       op = OP_U16;
                        4:       op = OP_U32;
                        5:       op = OP_U64;
                        6:       op = OP_RAW8;
                        7, 8:    op = OP_FLAG;
                        9:       op = OP_RSV_BIT;
                        10:      op = OP_RSV_BYTE;
                        default: op = OP_FLUSH;
                    endcase
                end
                3'd1: begin
                    k = $urandom_range(0, 5);
                    case (k)
                        0, 1, 2: op = OP_ATTR;
                        3:       op = OP_FLAG;
                        4:       op = OP_RSV_BIT;
                        default: op = OP_FLUSH;
                    endcase
                end
                3'd4: begin
                    k = $urandom_range(0, 4);
                    case (k)
                        0, 1:    op = OP_NIBBLE;
                        2:       op = OP_FLAG;
                        3:       op = OP_RSV_BIT;
                        default: op = OP_FLUSH;
                    endcase
                end
                default: begin
                    k = $urandom_range(0, 4);
                    case (k)
                        0, 1:    op = OP_FLAG;
                        2, 3:    op = OP_RSV_BIT;
                        default: op = OP_FLUSH;
                    endcase
                end
            endcase
        end
        k = $urandom_range(0, 9);
        case (k)
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'h1 << $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
    endtask

    // Offer one request after a random gap and hold it until it is taken
    task automatic send_req(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
                            input logic typed, input result_t res);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        req_tags.push_back({typed, res});
        s_op    = op;
        s_value = v;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Pause the sender until every expected byte has come out
    task automatic drain_stream();
        s_valid = 1'b0;
        while (exp_stream.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready   = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge aclk) begin : monitor_blk
        req_tag_t tag;
        result_t  got;
        result_t  want;
        if (!aresetn) begin
            stall_cycles = 0;
        end else begin
            if (s_valid && s_ready) begin
                tag = req_tags.pop_front();
                pack_field(s_op, s_value);
                if (tag.typed) exp_stream.push_back(tag.res);
                else foreach (burst[j]) exp_stream.push_back(burst[j]);
            end
            if (m_valid && m_ready) begin
                got = {m_out_byte, m_byte_valid, m_error, m_last};
                if (exp_stream.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: byte %h bv %b err %b last %b",
                                 got.data, got.bv, got.err, got.last);
                end else begin
                    want = exp_stream.pop_front();
                    if (got.data !== want.data || got.bv !== want.bv ||
                        got.err !== want.err || got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch: expected byte %h bv %b err %b last %b, got byte %h bv %b err %b last %b",
                                     want.data, want.bv, want.err, want.last,
                                     got.data, got.bv, got.err, got.last);
                    end
                end
            end
            // Drop out if neither channel moves for too long
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] v;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = '0;
        s_value      = '0;
        m_ready      = 1'b0;
        pk_open      = '0;
        pk_pos       = '0;
        hold_req     = 1'b0;
        hold_taken   = 1'b0;
        hold_left    = 0;
        fail_count   = 0;
        stall_cycles = 0;
        snd_idle_pct = 16;
        rcv_idle_pct = 68;

        // Directed table: typed rows carry one result read straight off the spec
        dir_rows = '{
            {OP_BYTE,       64'h0000_0000_0000_00FF, 1'b1, 8'hFF, 3'b101},
            {OP_BYTE,       64'hFFFF_FFFF_FFFF_FF00, 1'b1, 8'h00, 3'b101},
            {OP_U16,        64'hFFFF_FFFF_FFFF_1234, 1'b0, 8'h00, 3'b000},
            {OP_U32,        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 3'b000},
            {OP_U64,        64'h0123_4567_89AB_CDEF, 1'b0, 8'h00, 3'b000},
            {OP_RAW8,       64'h0123_4567_89AB_CDEF, 1'b0, 8'h00, 3'b000},
            {OP_U64,        64'h0000_0000_0000_0000, 1'b0, 8'h00, 3'b000},
            {OP_RSV_BYTE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h00, 3'b101},
            {OP_FLUSH,      64'h0000_0000_0000_0000, 1'b0, 8'h00, 3'b000},
            {OP_NIBBLE,     64'h0000_0000_0000_000A, 1'b0, 8'h00, 3'b000},
            {OP_BYTE,       64'h0000_0000_0000_0055, 1'b1, 8'h00, 3'b011},
            {OP_ATTR,       64'h0000_0000_0000_7FFF, 1'b1, 8'h00, 3'b011},
            {OP_U64,        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h00, 3'b011},
            {OP_NIBBLE,     64'hFFFF_FFFF_FFFF_FFF5, 1'b1, 8'hA5, 3'b101},
            {OP_FLAG,       64'h0000_0000_0000_0001, 1'b0, 8'h00, 3'b000},
            {OP_ATTR,       64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 3'b000},
            {OP_RSV_BIT,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 3'b000},
            {OP_ATTR,       64'h0000_0000_0000_1234, 1'b0, 8'h00, 3'b000},
            {OP_FLAG,       64'h0000_0000_0000_0000, 1'b0, 8'h00, 3'b000},
            {OP_FLAG,       64'h8000_0000_0000_0000, 1'b0, 8'h00, 3'b000},
            {OP_NIBBLE,     64'h0000_0000_0000_0003, 1'b1, 8'h00, 3'b011},
            {OP_ATTR,       64'h0000_0000_0000_0001, 1'b1, 8'h00, 3'b011},
            {OP_FLUSH,      64'h0000_0000_0000_0000, 1'b0, 8'h00, 3'b000},
            {OP_UNKNOWN_LO, 64'h0000_0000_0000_0000, 1'b1, 8'h00, 3'b011},
            {OP_UNKNOWN_HI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h00, 3'b011}
        };

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_req(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
        drain_stream();

        // Random phases: slow receiver, then slow sender, then no idling
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 68 : 0;
            rcv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 16 : 0;
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                if (ph == 0 && i == 40) hold_req = 1'b1;
                pick_request(op, v);
                send_req(op, v, 1'b0, '0);
            end
            drain_stream();
        end

        repeat (16) @(negedge aclk);
        if (fail_count == 0 && exp_stream.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/msbfp_pkg.sv
src/msbfp_front.sv
src/msbfp_queue.sv
src/msbfp_back.sv
src/msb_first_field_packer_core.sv
dv/testbench.sv
